/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for fixed_point_log2_q16; define NO_ASSERTIONS to
// compile them away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising clock edge outside reset
`define ASSERT_AT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Check that an expression never holds outside reset
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_AT(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

/* design/flog2_pkg.sv */
// ----------------------------------------------------------------------------
// flog2_pkg
// Widths, pipeline depth and the stage record of the Q16 binary log unit.
// ----------------------------------------------------------------------------
package flog2_pkg;

   // Fraction bits produced, one squaring stage each
   localparam int FRACTION_BITS = 16;

   localparam int OPERAND_W  = 32;
   localparam int MANT_W     = 32;
   localparam int INT_W      = 5;
   localparam int LOG2_W     = 21;
   localparam int RSP_DATA_W = 24;
   localparam int FULL_W     = INT_W + FRACTION_BITS;

   // Input register plus two normalize stages ahead of the squarers
   localparam int NORM_STAGES = 3;
   localparam int PIPE_DEPTH  = NORM_STAGES + FRACTION_BITS;

   // What travels down the pipeline with each item
   typedef struct packed {
      logic                     zero;
      logic [INT_W-1:0]         ipart;
      logic [MANT_W-1:0]        mant;
      logic [FRACTION_BITS-1:0] frac;
   } stage_type;

endpackage

/* design/fixed_point_log2_q16.sv */
// ----------------------------------------------------------------------------
// fixed_point_log2_q16
// Pipelined base-2 logarithm of an unsigned 32-bit value, result in Q16.
// ----------------------------------------------------------------------------
//   channel | direction | tdata (low bit up)     | tuser
//   req     | in        | operand_value[31:0]    | -
//   rsp     | out       | log2_result[20:0], pad | zero_error
//
// One item enters per cycle while the output is not stalled; it passes the
// input register, two normalize stages, one squaring stage per fraction bit
// with one 32x32 multiplier each, and the output register.
// Reset (synchronous, active high) clears all valid bits; data needs none.
// A stalled result holds the output register; the pipeline keeps moving
// while its last stage is empty, so items are still taken during a stall.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fixed_point_log2_q16 (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [flog2_pkg::OPERAND_W-1:0]    req_tdata,   // operand_value[31:0]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [flog2_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // log2_result[20:0], zeros
   output logic [0:0]                         rsp_tuser    // zero_error
);

   localparam int LAST = flog2_pkg::PIPE_DEPTH - 1;

   logic [flog2_pkg::PIPE_DEPTH-1:0] valid_ff;
   logic [flog2_pkg::PIPE_DEPTH-1:0] valid_in;
   flog2_pkg::stage_type             stage_ff [flog2_pkg::PIPE_DEPTH];
   flog2_pkg::stage_type             stage_in [flog2_pkg::PIPE_DEPTH];

   logic                             pipe_en;
   logic                             out_load;
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   logic [flog2_pkg::LOG2_W-1:0]     result_ff;
   logic [flog2_pkg::LOG2_W-1:0]     result_in;
   logic                             zero_ff;
   logic                             zero_in;
   logic [flog2_pkg::LOG2_W+flog2_pkg::FULL_W-1:0] result_wide;

   // Advance the pipeline unless a full last stage faces a stalled output
   always_comb begin
      out_load   = !rsp_valid_ff || rsp_tready;
      pipe_en    = !valid_ff[LAST] || out_load;
      req_tready = pipe_en;
   end

   // Shift valid bits along with the data
   always_comb begin
      valid_in[0] = req_tvalid;
      for (int i = 1; i < flog2_pkg::PIPE_DEPTH; i++) begin
         valid_in[i] = valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (pipe_en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int i = 0; i < flog2_pkg::PIPE_DEPTH; i++) begin
            stage_ff[i] <= stage_in[i];
         end
      end
   end

   // Capture the operand
   always_comb begin
      stage_in[0].zero  = 1'b0;
      stage_in[0].ipart = '0;
      stage_in[0].mant  = req_tdata;
      stage_in[0].frac  = '0;
   end

   // Normalize, coarse part: shift by 16 and 8, keep the upper count bits
   always_comb begin
      logic [31:0] x;
      logic [31:0] x16;
      logic [31:0] x8;
      logic        s16;
      logic        s8;
      x   = stage_ff[0].mant;
      s16 = (x[31:16] == 16'h0000);
      x16 = s16 ? {x[15:0], 16'h0000} : x;
      s8  = (x16[31:24] == 8'h00);
      x8  = s8 ? {x16[23:0], 8'h00} : x16;
      stage_in[1].zero  = (x == 32'h0000_0000);
      stage_in[1].ipart = {s16, s8, 3'b000};
      stage_in[1].mant  = x8;
      stage_in[1].frac  = '0;
   end

   // Normalize, fine part: shift by 4, 2 and 1; integer part is 31 - count
   always_comb begin
      logic [31:0] y;
      logic [31:0] y4;
      logic [31:0] y2;
      logic [31:0] y1;
      logic        s4;
      logic        s2;
      logic        s1;
      y  = stage_ff[1].mant;
      s4 = (y[31:28] == 4'h0);
      y4 = s4 ? {y[27:0], 4'h0} : y;
      s2 = (y4[31:30] == 2'b00);
      y2 = s2 ? {y4[29:0], 2'b00} : y4;
      s1 = !y2[31];
      y1 = s1 ? {y2[30:0], 1'b0} : y2;
      stage_in[2].zero  = stage_ff[1].zero;
      stage_in[2].ipart = ~{stage_ff[1].ipart[4:3], s4, s2, s1};
      stage_in[2].mant  = y1;
      stage_in[2].frac  = '0;
   end

   // Square the mantissa once per stage; a square of 2.0 or more sets the bit
   for (genvar k = 0; k < flog2_pkg::FRACTION_BITS; k++) begin : g_square
      localparam int IDX = flog2_pkg::NORM_STAGES + k;

      logic [2*flog2_pkg::MANT_W-1:0]  prod;
      logic [flog2_pkg::MANT_W:0]      sq;
      logic [flog2_pkg::FRACTION_BITS:0] frac_wide;

      always_comb begin
         prod      = stage_ff[IDX-1].mant * stage_ff[IDX-1].mant;
         sq        = prod[2*flog2_pkg::MANT_W-1:flog2_pkg::MANT_W-1];
         frac_wide = {stage_ff[IDX-1].frac, sq[flog2_pkg::MANT_W]};
         stage_in[IDX].zero  = stage_ff[IDX-1].zero;
         stage_in[IDX].ipart = stage_ff[IDX-1].ipart;
         stage_in[IDX].mant  = sq[flog2_pkg::MANT_W] ? sq[flog2_pkg::MANT_W:1]
                                                     : sq[flog2_pkg::MANT_W-1:0];
         stage_in[IDX].frac  = frac_wide[flog2_pkg::FRACTION_BITS-1:0];
      end
   end

   // Assemble the result from the integer part and the fraction bits
   always_comb begin
      result_wide  = {{flog2_pkg::LOG2_W{1'b0}}, stage_ff[LAST].ipart, stage_ff[LAST].frac};
      zero_in      = stage_ff[LAST].zero;
      result_in    = zero_in ? '0 : result_wide[flog2_pkg::LOG2_W-1:0];
      rsp_valid_in = out_load ? valid_ff[LAST] : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         result_ff <= result_in;
         zero_ff   <= zero_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(flog2_pkg::RSP_DATA_W - flog2_pkg::LOG2_W){1'b0}}, result_ff};
   assign rsp_tuser  = zero_ff;

   // An accepted item lands in the input register
   `ASSERT_AT(a_accept_lands, clock, reset, (req_tvalid && req_tready) |=> valid_ff[0])
   // A stalled last stage keeps its item
   `ASSERT_AT(a_last_holds, clock, reset, (valid_ff[LAST] && !pipe_en) |=> valid_ff[LAST])
   // The pipeline only stops behind a waiting result
   `ASSERT_AT(a_stall_cause, clock, reset, !pipe_en |-> rsp_valid_ff)
   // A zero operand never reports a nonzero logarithm
   `ASSERT_NEVER(a_zero_result, clock, reset, rsp_valid_ff && zero_ff && (result_ff != '0))

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives operands into the pipelined Q16 binary log unit and checks every
// result against a predictor that squares the normalized mantissa once per
// fraction bit. Both stream sides idle at random. One long receiver hold-off
// fills the pipeline so that it stalls its input.
// ----------------------------------------------------------------------------
module testbench;

   localparam int FB         = flog2_pkg::FRACTION_BITS;
   localparam int OPERAND_W  = flog2_pkg::OPERAND_W;
   localparam int LOG2_W     = flog2_pkg::LOG2_W;
   localparam int RSP_DATA_W = flog2_pkg::RSP_DATA_W;
   localparam int DRAIN_CYC  = flog2_pkg::PIPE_DEPTH + 8;
   localparam int RANDOM_OPS = 400;
   localparam int IDLE_PCT   = 6;
   // Receiver hold-off and idle-free window, in receiver cycles
   localparam int HOLD_START   = 200;
   localparam int HOLD_CYCLES  = 60;
   localparam int STEADY_START = 40;
   localparam int STEADY_END   = 180;

   // -------------------------------------------------------------------------
   // Expected results and their check
   // -------------------------------------------------------------------------
   class log2_scoreboard;
      typedef struct packed {
         logic [LOG2_W-1:0] log2;
         logic              zero_err;
      } log2_answer_type;

      log2_answer_type pending_logs[$];
      int              errors = 0;

      // Integer part from the top set bit, fraction by repeated squaring
      function log2_answer_type predict_log2(logic [OPERAND_W-1:0] v);
         log2_answer_type ans;
         logic [63:0]  mant;
         logic [63:0]  sq;
         logic [63:0]  full;
         logic [FB-1:0] frac;
         int           ipart;
         ipart = 0;
         frac  = '0;
         if (v == '0) begin
            ans.log2     = '0;
            ans.zero_err = 1'b1;
            return ans;
         end
         for (int i = 0; i < OPERAND_W; i++) begin
            if (v[i]) ipart = i;
         end
         mant = {32'b0, v} << (31 - ipart);
         for (int b = FB - 1; b >= 0; b--) begin
            sq = (mant * mant) >> 31;
            // square reached 2.0: set the bit and halve
            if (sq[32]) begin
               sq      = sq >> 1;
               frac[b] = 1'b1;
            end
            mant = sq;
         end
         full = (64'(ipart) << FB) | 64'(frac);
         ans.log2     = full[LOG2_W-1:0];
         ans.zero_err = 1'b0;
         return ans;
      endfunction

      function void note_operand(logic [OPERAND_W-1:0] v);
         pending_logs.push_back(predict_log2(v));
      endfunction

      task report_mismatch(string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      task check_result(logic [RSP_DATA_W-1:0] tdata, logic [0:0] tuser);
         log2_answer_type want;
         if (pending_logs.size() == 0) begin
            report_mismatch($sformatf("result %h/%b with nothing expected", tdata, tuser));
            return;
         end
         want = pending_logs.pop_front();
         if (tdata[LOG2_W-1:0] !== want.log2)
            report_mismatch($sformatf("log2_result %h, expected %h",
                                      tdata[LOG2_W-1:0], want.log2));
         if (tdata[RSP_DATA_W-1:LOG2_W] !== '0)
            report_mismatch($sformatf("pad bits %b not zero", tdata[RSP_DATA_W-1:LOG2_W]));
         if (tuser[0] !== want.zero_err)
            report_mismatch($sformatf("zero_error %b, expected %b", tuser[0], want.zero_err));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and the block
   // -------------------------------------------------------------------------
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [OPERAND_W-1:0]  req_tdata  = '0;   // operand_value[31:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // log2_result[20:0], zeros
   logic [0:0]            rsp_tuser;          // zero_error

   logic           steady = 1'b0;
   log2_scoreboard sb     = new();

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   fixed_point_log2_q16 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // -------------------------------------------------------------------------
   // Watch both channels at the rising edge
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_operand(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
      end
   end

   // -------------------------------------------------------------------------
   // Sender: offer one operand, idling now and then
   // -------------------------------------------------------------------------
   task send_operand(input logic [OPERAND_W-1:0] v);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Random operand: mostly short values so every top-bit index shows up
   function logic [OPERAND_W-1:0] pick_operand();
      int          kind;
      int          k;
      logic [31:0] v;
      kind = $urandom_range(0, 99);
      k    = $urandom_range(0, 31);
      if (kind < 3)
         v = '0;
      else if (kind < 50)
         v = $urandom() >> k;
      else if (kind < 65)
         // near a power of two, where fraction bits flip
         v = (32'd1 << k) + 32'($urandom_range(0, 6)) - 32'd3;
      else
         v = $urandom();
      return v;
   endfunction

   // -------------------------------------------------------------------------
   // Receiver: random stalls, one idle-free window and one long hold-off
   // -------------------------------------------------------------------------
   initial begin
      int rx_cycle;
      rx_cycle = 0;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         rx_cycle++;
         if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES)
            rsp_tready <= 1'b0;
         else if (rx_cycle >= STEADY_START && rx_cycle < STEADY_END)
            rsp_tready <= 1'b1;
         else
            rsp_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus and end of run
   // -------------------------------------------------------------------------
   initial begin
      logic [OPERAND_W-1:0] directed_ops[$];
      directed_ops = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
                       32'h0000_0004, 32'h0000_0005, 32'h0000_0007, 32'hFFFF_FFFF,
                       32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001, 32'hFFFF_FFFE,
                       32'h0001_0000, 32'h0000_FFFF, 32'h0001_0001, 32'hAAAA_AAAA,
                       32'h5555_5555, 32'hC000_0000, 32'hB504_F334, 32'h0000_0000,
                       32'h4000_0000, 32'h1234_5678, 32'h0000_0006};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // extremes, zero and values around powers of two
      foreach (directed_ops[i]) send_operand(directed_ops[i]);

      for (int n = 0; n < RANDOM_OPS; n++) begin
         steady = (n >= 150 && n < 250);
         send_operand(pick_operand());
      end
      req_tvalid <= 1'b0;

      // drain
      while (sb.pending_logs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
      if (sb.errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Hard stop well past the slowest correct run
   initial begin
      #400000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
